// ===== hdl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the advertisement sensor decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  // Bytes of one advertisement that are parsed; later bytes are dropped
  localparam logic [7:0] MAX_ADV_BYTES = 8'd255;

  // AD structure type of manufacturer-specific data
  localparam logic [7:0] AD_TYPE_MAKER = 8'hFF;
  // Least structure length that holds type and 16-bit identifier
  localparam logic [7:0] MIN_MAKER_LEN = 8'd3;
  // Least structure length that holds the full sensor record
  localparam logic [7:0] MIN_RECORD_LEN = 8'd8;
  // Least advertisement length that can carry a result
  localparam logic [7:0] MIN_ADV_LEN = 8'd4;

  // Encoded value split: sign in bit 23, magnitude below it
  localparam int SIGN_POS = 23;
  localparam int MAG_W = 23;
  localparam int QUOT_W = 14;
  localparam logic [22:0] SPLIT = 23'd1000;
  // floor(m / 1000) == (m * RECIP_K) >> RECIP_SHIFT for every 23-bit m
  localparam int RECIP_SHIFT = 33;
  localparam logic [23:0] RECIP_K = 24'd8589935;

  // Queue between parser and decoder
  localparam int QUEUE_DEPTH = 2;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_MATCH     = 2'd1,
    STATUS_TOO_SHORT    = 2'd2,
    STATUS_OUT_OF_RANGE = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAKER_ID   = 3'd0,
    REG_TEMP_LOW   = 3'd1,
    REG_TEMP_HIGH  = 3'd2,
    REG_HUM_LOW    = 3'd3,
    REG_HUM_HIGH   = 3'd4,
    REG_BATT_LIMIT = 3'd5
  } reg_index_t;

  // Register reset values
  localparam logic [15:0] MAKER_ID_RESET = 16'hEC88;
  localparam logic signed [14:0] TEMP_LOW_RESET = -15'sd8388;
  localparam logic signed [14:0] TEMP_HIGH_RESET = 15'sd8388;
  localparam logic [9:0] HUM_LOW_RESET = 10'd0;
  localparam logic [9:0] HUM_HIGH_RESET = 10'd999;
  localparam logic [7:0] BATT_LIMIT_RESET = 8'd100;

  // Range limits seen by the decoder
  typedef struct packed {
    logic signed [14:0] temp_low;
    logic signed [14:0] temp_high;
    logic [9:0]         hum_low;
    logic [9:0]         hum_high;
    logic [7:0]         batt_limit;
  } limits_t;

  // One parsed advertisement; kind STATUS_OK means "decode the value"
  typedef struct packed {
    status_t     kind;
    logic [23:0] encoded;
    logic [7:0]  battery;
  } adv_rec_t;

endpackage

`default_nettype wire

// ===== hdl/bsd_front.sv =====
// ----------------------------------------------------------------------------
// bsd_front
// Byte parser: walks the length-type structures, captures the matching
// manufacturer record and classifies the advertisement at its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      adv_byte,
  input  wire logic            last_byte,
  input  wire logic [15:0]     maker_id,
  output      logic            push,
  output      bsd_pkg::adv_rec_t push_rec
);

  // Parser state
  logic [7:0]  byte_position;
  logic [8:0]  next_field_start;
  logic [7:0]  field_length;
  logic        field_is_maker;
  logic [7:0]  id_low_byte;
  logic        scan_stopped;
  logic        match_found;
  logic [8:0]  match_end;
  logic [7:0]  payload_count;
  logic [23:0] encoded_value;
  logic [7:0]  battery_value;

  logic [7:0]  byte_position_next;
  logic [8:0]  next_field_start_next;
  logic [7:0]  field_length_next;
  logic        field_is_maker_next;
  logic [7:0]  id_low_byte_next;
  logic        scan_stopped_next;
  logic        match_found_next;
  logic [8:0]  match_end_next;
  logic [7:0]  payload_count_next;
  logic [23:0] encoded_value_next;
  logic [7:0]  battery_value_next;

  logic [10:0] rel;

  // Offset of the current byte within the open structure
  assign rel = 11'(byte_position) + 11'(field_length) + 11'd1 - 11'(next_field_start);

  // Next parser state for the byte at the input
  always_comb begin
    byte_position_next    = byte_position;
    next_field_start_next = next_field_start;
    field_length_next     = field_length;
    field_is_maker_next   = field_is_maker;
    id_low_byte_next      = id_low_byte;
    scan_stopped_next     = scan_stopped;
    match_found_next      = match_found;
    match_end_next        = match_end;
    payload_count_next    = payload_count;
    encoded_value_next    = encoded_value;
    battery_value_next    = battery_value;
    if (byte_position < bsd_pkg::MAX_ADV_BYTES) begin
      byte_position_next = byte_position + 8'd1;
      if (match_found) begin
        // collect the record bytes that follow the identifier
        if ({1'b0, byte_position} <= match_end) begin
          if (payload_count >= 8'd1 && payload_count <= 8'd3) begin
            encoded_value_next = {encoded_value[15:0], adv_byte};
          end else if (payload_count == 8'd4) begin
            battery_value_next = adv_byte;
          end
          if (payload_count != 8'hFF) begin
            payload_count_next = payload_count + 8'd1;
          end
        end
      end else if (!scan_stopped) begin
        if ({1'b0, byte_position} == next_field_start) begin
          // length byte opens a structure
          field_length_next   = adv_byte;
          field_is_maker_next = 1'b0;
          if (adv_byte == 8'd0) begin
            scan_stopped_next = 1'b1;
          end else begin
            next_field_start_next = 9'(byte_position) + 9'(adv_byte) + 9'd1;
          end
        end else if (rel == 11'd1) begin
          field_is_maker_next = (adv_byte == bsd_pkg::AD_TYPE_MAKER) &&
                                (field_length >= bsd_pkg::MIN_MAKER_LEN);
        end else if (rel == 11'd2) begin
          id_low_byte_next = adv_byte;
        end else if (rel == 11'd3) begin
          if (field_is_maker && ({adv_byte, id_low_byte} == maker_id)) begin
            match_found_next   = 1'b1;
            match_end_next     = next_field_start - 9'd1;
            payload_count_next = 8'd0;
          end
        end
      end
    end
  end

  // Classification at the last byte
  always_comb begin
    push_rec.encoded = encoded_value_next;
    push_rec.battery = battery_value_next;
    if (byte_position_next < bsd_pkg::MIN_ADV_LEN || !match_found_next ||
        ({1'b0, match_end_next} + 10'd1) > 10'(byte_position_next)) begin
      push_rec.kind = bsd_pkg::STATUS_NO_MATCH;
    end else if (field_length_next < bsd_pkg::MIN_RECORD_LEN) begin
      push_rec.kind = bsd_pkg::STATUS_TOO_SHORT;
    end else begin
      push_rec.kind = bsd_pkg::STATUS_OK;
    end
  end

  assign push = accept && last_byte;

  // State update; the last byte returns the parser to its start
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position    <= '0;
      next_field_start <= '0;
      field_length     <= '0;
      field_is_maker   <= 1'b0;
      id_low_byte      <= '0;
      scan_stopped     <= 1'b0;
      match_found      <= 1'b0;
      match_end        <= '0;
      payload_count    <= '0;
      encoded_value    <= '0;
      battery_value    <= '0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      next_field_start <= next_field_start_next;
      field_length     <= field_length_next;
      field_is_maker   <= field_is_maker_next;
      id_low_byte      <= id_low_byte_next;
      scan_stopped     <= scan_stopped_next;
      match_found      <= match_found_next;
      match_end        <= match_end_next;
      payload_count    <= payload_count_next;
      encoded_value    <= encoded_value_next;
      battery_value    <= battery_value_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsd_queue.sv =====
// ----------------------------------------------------------------------------
// bsd_queue
// Short queue of parsed advertisements between parser and decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bsd_pkg::adv_rec_t push_rec,
  output      logic              full,
  input  wire logic              pop,
  output      logic              head_valid,
  output      bsd_pkg::adv_rec_t head_rec
);

  localparam int PTR_W = $clog2(bsd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bsd_pkg::QUEUE_DEPTH + 1);

  bsd_pkg::adv_rec_t entries [bsd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CNT_W'(bsd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsd_back.sv =====
// ----------------------------------------------------------------------------
// bsd_back
// Decoder: splits the encoded value by 1000 with a reciprocal multiply,
// applies the range limits and holds the result for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bsd_pkg::limits_t  limits,
  input  wire logic              rec_valid,
  input  wire bsd_pkg::adv_rec_t rec,
  output      logic              rec_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      bsd_pkg::status_t  status,
  output      logic signed [14:0] temperature_raw,
  output      logic [9:0]        hum_remainder,
  output      logic [7:0]        battery_level
);

  logic        advance;
  logic [46:0] prod;

  // stage 1: quotient
  logic                       v1;
  bsd_pkg::status_t           kind1;
  logic [bsd_pkg::MAG_W-1:0]  mag1;
  logic                       sign1;
  logic [7:0]                 batt1;
  logic [bsd_pkg::QUOT_W-1:0] quot1;

  // stage 2: remainder and signed temperature
  logic               v2;
  bsd_pkg::status_t   kind2;
  logic signed [14:0] temp2;
  logic [9:0]         hum2;
  logic [7:0]         batt2;
  logic [22:0]        rem;
  logic               in_range;

  // whole pipeline moves while the output register can take a result
  assign advance = !out_valid || out_ready;
  assign rec_pop = advance && rec_valid;

  assign prod = 47'(rec.encoded[bsd_pkg::MAG_W-1:0]) * 47'(bsd_pkg::RECIP_K);
  assign rem  = mag1 - 23'(quot1) * bsd_pkg::SPLIT;

  always_comb begin
    in_range = (temp2 >= limits.temp_low) && (temp2 <= limits.temp_high) &&
               (hum2 >= limits.hum_low) && (hum2 <= limits.hum_high) &&
               (batt2 <= limits.batt_limit);
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= rec_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      kind1 <= rec.kind;
      mag1  <= rec.encoded[bsd_pkg::MAG_W-1:0];
      sign1 <= rec.encoded[bsd_pkg::SIGN_POS];
      batt1 <= rec.battery;
      quot1 <= prod[bsd_pkg::RECIP_SHIFT +: bsd_pkg::QUOT_W];

      kind2 <= kind1;
      hum2  <= rem[9:0];
      temp2 <= sign1 ? -$signed({1'b0, quot1}) : $signed({1'b0, quot1});
      batt2 <= batt1;

      if (kind2 == bsd_pkg::STATUS_OK) begin
        status          <= in_range ? bsd_pkg::STATUS_OK : bsd_pkg::STATUS_OUT_OF_RANGE;
        temperature_raw <= temp2;
        hum_remainder   <= hum2;
        battery_level   <= batt2;
      end else begin
        status          <= kind2;
        temperature_raw <= '0;
        hum_remainder   <= '0;
        battery_level   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ble_adv_sensor_decoder.sv =====
// ----------------------------------------------------------------------------
// ble_adv_sensor_decoder
// Parses a BLE advertisement byte stream and decodes one sensor record.
// ----------------------------------------------------------------------------
// Takes one advertisement byte per clock on the slave stream, with tlast on
// the final byte, and gives one result per advertisement on the master
// stream. A parser runs at one byte per cycle; at the last byte it pushes a
// classified record into a two-entry queue. The decoder behind it is a
// three-stage pipeline (reciprocal multiply for the split by 1000, remainder
// and sign, range check into the output register), so a result passes from
// the queue through the stage-1 and stage-2 registers into the output
// register; one result per cycle can be drained. The input stalls only when
// the queue is full, i.e. while results back up at the output. The user must
// write the limit and identifier registers through the cfg port only while
// no advertisement is in flight; the block itself does not enforce this.
`default_nettype none

module ble_adv_sensor_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] adv_byte
  input  wire logic        s_tlast,   // last_byte
  // result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [14:0] temperature_raw, [24:15] hum_remainder,
                                      // [32:25] battery_level, [39:33] zero
  output      logic [1:0]  m_tuser,   // [1:0] status
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]       maker_id;
  bsd_pkg::limits_t  limits;

  logic              accept;
  logic              push;
  bsd_pkg::adv_rec_t push_rec;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  bsd_pkg::adv_rec_t q_rec;

  bsd_pkg::status_t   status;
  logic signed [14:0] temperature_raw;
  logic [9:0]         hum_remainder;
  logic [7:0]         battery_level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      maker_id          <= bsd_pkg::MAKER_ID_RESET;
      limits.temp_low   <= bsd_pkg::TEMP_LOW_RESET;
      limits.temp_high  <= bsd_pkg::TEMP_HIGH_RESET;
      limits.hum_low    <= bsd_pkg::HUM_LOW_RESET;
      limits.hum_high   <= bsd_pkg::HUM_HIGH_RESET;
      limits.batt_limit <= bsd_pkg::BATT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (bsd_pkg::reg_index_t'(cfg_index))
        bsd_pkg::REG_MAKER_ID:   maker_id          <= cfg_data;
        bsd_pkg::REG_TEMP_LOW:   limits.temp_low   <= cfg_data[14:0];
        bsd_pkg::REG_TEMP_HIGH:  limits.temp_high  <= cfg_data[14:0];
        bsd_pkg::REG_HUM_LOW:    limits.hum_low    <= cfg_data[9:0];
        bsd_pkg::REG_HUM_HIGH:   limits.hum_high   <= cfg_data[9:0];
        bsd_pkg::REG_BATT_LIMIT: limits.batt_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  bsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .adv_byte  (s_tdata),
    .last_byte (s_tlast),
    .maker_id  (maker_id),
    .push      (push),
    .push_rec  (push_rec)
  );

  bsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (q_rec)
  );

  bsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .limits          (limits),
    .rec_valid       (q_valid),
    .rec             (q_rec),
    .rec_pop         (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .status          (status),
    .temperature_raw (temperature_raw),
    .hum_remainder   (hum_remainder),
    .battery_level   (battery_level)
  );

  // Result packing
  assign m_tdata = {7'd0, battery_level, hum_remainder, temperature_raw};
  assign m_tuser = status;

endmodule

`default_nettype wire
